/* hdl/tcsw_pkg.sv */
// Shared types, codes and constants for the text console screen writer.
package tcsw_pkg;

    // Default geometry handed to the top-level parameters
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Beat widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int OFFSET_W    = 13;

    // Commands carried in tuser
    localparam logic [IN_TUSER_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [IN_TUSER_W-1:0] CMD_SET   = 2'd1;
    localparam logic [IN_TUSER_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE = 2'd2;

    // Control characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Cell = {attribute, character}
    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [15:0] TITLE_CELL = 16'h1F20;
    localparam logic [7:0]  ATTR_RESET = 8'h0F;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic tab_step;
        logic scroll_start;
        logic copy_step;
        logic blank_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_tab;
        logic tab_last;
        logic need_scroll;
        logic clear_last;
        logic copy_done;
        logic blank_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* hdl/tcsw_ctrl.sv */
// Sequencing state machine: clear pass, item intake, tab walk, scroll and result hand-off.
module tcsw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tcsw_pkg::t_dp_sts i_sts,
    output tcsw_pkg::t_dp_cmd o_cmd
);
    import tcsw_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_TAB   = 7'b0000100,
        S_DONE  = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_BLANK = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.is_tab ? S_TAB : S_DONE;
                end
            end
            S_TAB: begin
                o_cmd.tab_step = 1'b1;
                if (i_sts.tab_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.need_scroll) begin
                    o_cmd.scroll_start = 1'b1;
                    n_state            = S_COPY;
                end else if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_done) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_sts.blank_last) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/tcsw_dp.sv */
// Datapath: screen memory, cursor, tab and scroll pointers, settings and result register.
module tcsw_dp #(
    parameter int COLUMNS  = tcsw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcsw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcsw_pkg::TAB_STOP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [tcsw_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [tcsw_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [tcsw_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                i_cfg_valid,
    input  logic [tcsw_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tcsw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  tcsw_pkg::t_dp_cmd                   i_cmd,
    output tcsw_pkg::t_dp_sts                   o_sts
);
    import tcsw_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int PTR_W  = $clog2(CELLS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CIDX_W = (PTR_W > 11) ? PTR_W : 11;
    localparam int TAB_N  = 2 ** COL_W;

    // Screen memory
    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    // Cursor and walk state
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_tab_end, n_tab_end;
    logic [PTR_W-1:0] r_src, n_src;
    logic [PTR_W-1:0] r_dst, n_dst;
    logic             r_pend, n_pend;

    // Per-item flags
    logic r_status, n_status;
    logic r_upd_req, n_upd_req;
    logic r_scrolled, n_scrolled;
    logic r_is_read, n_is_read;
    logic r_rd_ok, n_rd_ok;

    // Settings
    logic [7:0] r_attr, n_attr;
    logic [1:0] r_page, n_page;
    logic       r_active, n_active;

    // Result register
    logic                   r_ovalid, n_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;

    // Input fields
    logic [7:0]  in_char;
    logic [6:0]  in_ncol;
    logic [4:0]  in_nrow;
    logic [10:0] in_cidx;

    logic [COL_W-1:0]    tab_tbl [TAB_N];
    logic [PTR_W-1:0]    cur_addr;
    logic [COL_W-1:0]    col_inc;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;
    logic [CIDX_W-1:0]   cidx_wide;
    logic                cidx_ok;
    logic                set_ok;
    logic                is_write;
    logic                is_ctrl_char;
    logic                copy_rd;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          out_char;
    logic [7:0]          out_attr;

    // Next tab stop for each column, clipped to the row end
    for (genvar g = 0; g < TAB_N; g++) begin : g_tab
        localparam int TV = (g / TAB_STOP + 1) * TAB_STOP;
        assign tab_tbl[g] = COL_W'((TV > COLUMNS) ? COLUMNS : TV);
    end

    assign in_char = i_s_tdata[7:0];
    assign in_ncol = i_s_tdata[14:8];
    assign in_nrow = i_s_tdata[19:15];
    assign in_cidx = i_s_tdata[30:20];

    assign cur_addr  = PTR_W'(r_row) * PTR_W'(COLUMNS) + PTR_W'(r_col);
    assign col_inc   = r_col + COL_W'(1);
    assign adv_col   = (col_inc == COL_W'(COLUMNS)) ? '0 : col_inc;
    assign adv_row   = (col_inc == COL_W'(COLUMNS)) ? r_row + ROW_W'(1) : r_row;
    assign cidx_wide = CIDX_W'(in_cidx);
    assign cidx_ok   = cidx_wide < CIDX_W'(CELLS);
    assign set_ok    = ({1'b0, in_ncol} < 8'(COLUMNS)) && ({1'b0, in_nrow} < 6'(ROWS - 1));
    assign is_write  = i_s_tuser == CMD_WRITE;
    assign is_ctrl_char = (in_char == CH_CR) || (in_char == CH_LF) ||
                          (in_char == CH_BS) || (in_char == CH_TAB);
    assign copy_rd   = r_src != PTR_W'(CELLS);

    assign offset   = OFFSET_W'(r_row) * OFFSET_W'(COLUMNS) + OFFSET_W'(r_col) +
                      {r_page, 11'd0};
    assign out_char = (r_is_read && r_rd_ok) ? r_rdata[7:0]  : 8'd0;
    assign out_attr = (r_is_read && r_rd_ok) ? r_rdata[15:8] : 8'd0;

    assign o_sts.is_tab      = is_write && (in_char == CH_TAB);
    assign o_sts.tab_last    = col_inc == r_tab_end;
    assign o_sts.need_scroll = r_row == ROW_W'(ROWS);
    assign o_sts.clear_last  = r_dst == PTR_W'(CELLS - 1);
    assign o_sts.copy_done   = !copy_rd && !r_pend;
    assign o_sts.blank_last  = r_dst == PTR_W'(CELLS - 1);
    assign o_sts.out_free    = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr[ADDR_W-1:0];
        mem_wdata = {r_attr, in_char};
        if (i_cmd.clear_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_dst[ADDR_W-1:0];
            mem_wdata = (r_dst < PTR_W'(COLUMNS)) ? TITLE_CELL : BLANK_CELL;
        end else if (i_cmd.accept && is_write && !is_ctrl_char) begin
            mem_we = 1'b1;
        end else if (i_cmd.tab_step) begin
            mem_we    = 1'b1;
            mem_wdata = {r_attr, CH_SPACE};
        end else if (i_cmd.copy_step && r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_dst[ADDR_W-1:0];
            mem_wdata = r_rdata;
        end else if (i_cmd.blank_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_dst[ADDR_W-1:0];
            mem_wdata = BLANK_CELL;
        end

        mem_re    = 1'b0;
        mem_raddr = cidx_wide[ADDR_W-1:0];
        if (i_cmd.accept && (i_s_tuser == CMD_READ) && cidx_ok) begin
            mem_re = 1'b1;
        end else if (i_cmd.copy_step && copy_rd) begin
            mem_re    = 1'b1;
            mem_raddr = r_src[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_tab_end  = r_tab_end;
        n_src      = r_src;
        n_dst      = r_dst;
        n_pend     = r_pend;
        n_status   = r_status;
        n_upd_req  = r_upd_req;
        n_scrolled = r_scrolled;
        n_is_read  = r_is_read;
        n_rd_ok    = r_rd_ok;
        n_attr     = r_attr;
        n_page     = r_page;
        n_active   = r_active;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_odata    = r_odata;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTR:   n_attr   = i_cfg_data;
                CFG_PAGE:   n_page   = i_cfg_data[1:0];
                CFG_ACTIVE: n_active = i_cfg_data[0];
                default:    ;
            endcase
        end

        if (i_cmd.accept) begin
            n_status   = 1'b0;
            n_upd_req  = 1'b0;
            n_scrolled = 1'b0;
            n_is_read  = i_s_tuser == CMD_READ;
            n_rd_ok    = cidx_ok;
            unique case (i_s_tuser)
                CMD_WRITE: begin
                    n_upd_req = i_s_tlast;
                    priority if (in_char == CH_CR) begin
                        n_col = '0;
                    end else if (in_char == CH_LF) begin
                        n_row = r_row + ROW_W'(1);
                    end else if (in_char == CH_BS) begin
                        if (r_col != '0) begin
                            n_col = r_col - COL_W'(1);
                        end
                    end else if (in_char == CH_TAB) begin
                        n_tab_end = tab_tbl[r_col];
                    end else begin
                        n_col = adv_col;
                        n_row = adv_row;
                    end
                end
                CMD_SET: begin
                    if (set_ok) begin
                        n_col     = COL_W'(in_ncol);
                        n_row     = ROW_W'({1'b0, in_nrow} + 6'd1);
                        n_upd_req = 1'b1;
                    end else begin
                        n_status = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.tab_step) begin
            n_col = adv_col;
            n_row = adv_row;
        end

        if (i_cmd.clear_step || i_cmd.blank_step) begin
            n_dst = r_dst + PTR_W'(1);
        end

        // Copy runs one read ahead of its write; source stays a full row past the sink
        if (i_cmd.scroll_start) begin
            n_row      = ROW_W'(ROWS - 1);
            n_scrolled = 1'b1;
            n_src      = PTR_W'(2 * COLUMNS);
            n_dst      = PTR_W'(COLUMNS);
            n_pend     = 1'b0;
        end

        if (i_cmd.copy_step) begin
            n_pend = copy_rd;
            if (copy_rd) begin
                n_src = r_src + PTR_W'(1);
            end
            if (r_pend) begin
                n_dst = r_dst + PTR_W'(1);
            end
        end

        if (i_cmd.load_out) begin
            n_ovalid = 1'b1;
            n_odata  = {4'd0, out_attr, out_char, r_scrolled, r_upd_req && r_active,
                        offset, 5'(r_row), 7'(r_col), r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= ROW_W'(1);
            r_dst    <= '0;
            r_pend   <= 1'b0;
            r_attr   <= ATTR_RESET;
            r_page   <= '0;
            r_active <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_dst    <= n_dst;
            r_pend   <= n_pend;
            r_attr   <= n_attr;
            r_page   <= n_page;
            r_active <= n_active;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab_end  <= n_tab_end;
        r_src      <= n_src;
        r_status   <= n_status;
        r_upd_req  <= n_upd_req;
        r_scrolled <= n_scrolled;
        r_is_read  <= n_is_read;
        r_rd_ok    <= n_rd_ok;
        r_odata    <= n_odata;
    end

endmodule

/* hdl/text_console_screen_writer.sv */
// Each item goes from intake to the result register; a tab first writes spaces up to its stop.
// A scroll shifts rows up, then blanks the last; one memory port pair moves a cell per cycle.
// Throughput: one item at a time; the next is taken while a finished result waits downstream.
// Reset: cursor to column 0 row 1, settings to defaults, then a clearing pass writes the
// title row and blank cells of the screen before the first item is taken.
module text_console_screen_writer #(
    parameter int COLUMNS  = tcsw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcsw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcsw_pkg::TAB_STOP_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // char_code[7:0], new_col[14:8], new_row[19:15], cell_index[30:20], zero[31]
    input  logic [tcsw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // command[1:0]
    input  logic [tcsw_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status[0], cursor_col[7:1], cursor_row[12:8], cursor_offset[25:13],
    // cursor_update[26], scrolled[27], read_char[35:28], read_attr[43:36], zero[47:44]
    output logic [tcsw_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcsw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tcsw_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcsw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    tcsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcsw_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
